// ===== design/tsopt_pkg.sv =====
`timescale 1ns / 1ps

package tsopt_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;

    localparam logic [BYTE_W-1:0] KIND_EOL = 8'd0;
    localparam logic [BYTE_W-1:0] KIND_NOP = 8'd1;
    localparam logic [BYTE_W-1:0] KIND_TS  = 8'd8;
    localparam logic [BYTE_W-1:0] TS_LEN   = 8'd10;
    localparam logic [BYTE_W-1:0] HDR_LEN  = 8'd2;
    localparam logic [BYTE_W-1:0] TS_BODY  = 8'd8;

    localparam int IN_DATA_W  = BYTE_W + 3 * WORD_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = BYTE_W;
    localparam int OUT_USER_W = 2;

    typedef enum logic [2:0] {
        MODE_KIND = 3'd0,
        MODE_LEN  = 3'd1,
        MODE_BODY = 3'd2,
        MODE_DONE = 3'd3,
        MODE_BAD  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] option_byte;
        logic              first_in_packet;
        logic              last_in_packet;
        logic [WORD_W-1:0] now_us;
        logic [WORD_W-1:0] tsval_offset;
        logic [WORD_W-1:0] tsecr_echo;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic              rewritten;
        logic              malformed;
    } out_item_t;

endpackage

// ===== design/tsopt_in_stage.sv =====
`timescale 1ns / 1ps

module tsopt_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsopt_pkg::in_item_t s_item,
    output logic                q_valid,
    input  logic                q_ready,
    output tsopt_pkg::in_item_t q_item
);
    import tsopt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// ===== design/tsopt_parser.sv =====
`timescale 1ns / 1ps

module tsopt_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  tsopt_pkg::in_item_t  item,
    output tsopt_pkg::out_item_t result
);
    import tsopt_pkg::*;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [BYTE_W-1:0] left_reg;
    logic [BYTE_W-1:0] left_next;
    logic              ts_reg;
    logic              ts_next;
    logic [WORD_W-1:0] send_reg;
    logic [WORD_W-1:0] send_next;
    logic [WORD_W-1:0] echo_reg;
    logic [WORD_W-1:0] echo_next;

    mode_t             mode;
    mode_t             step_mode;
    logic [BYTE_W-1:0] left;
    logic              ts;
    logic [2:0]        idx;
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] ts_byte;
    logic [BYTE_W-1:0] ob;
    logic              rw;
    logic              bad;

    always_comb begin
        mode      = item.first_in_packet ? MODE_KIND : mode_reg;
        left      = item.first_in_packet ? '0 : left_reg;
        ts        = item.first_in_packet ? 1'b0 : ts_reg;
        send_next = item.first_in_packet ? item.tsval_offset + item.now_us : send_reg;
        echo_next = item.first_in_packet ? item.tsecr_echo : echo_reg;
    end

    always_comb begin
        idx  = 3'(TS_BODY[3:0] - left[3:0]);
        word = idx[2] ? echo_next : send_next;
        unique case (idx[1:0])
            2'd0: ts_byte = word[31:24];
            2'd1: ts_byte = word[23:16];
            2'd2: ts_byte = word[15:8];
            2'd3: ts_byte = word[7:0];
        endcase
    end

    always_comb begin
        step_mode = mode;
        left_next = left;
        ts_next   = ts;
        ob        = item.option_byte;
        rw        = 1'b0;
        bad       = 1'b0;
        unique case (mode)
            MODE_KIND: begin
                if (item.option_byte == KIND_EOL) begin
                    step_mode = MODE_DONE;
                end else if (item.option_byte == KIND_NOP) begin
                    step_mode = MODE_KIND;
                end else begin
                    ts_next   = (item.option_byte == KIND_TS);
                    step_mode = MODE_LEN;
                    bad       = item.last_in_packet;
                end
            end
            MODE_LEN: begin
                if (item.option_byte < HDR_LEN) begin
                    bad = 1'b1;
                end else begin
                    left_next = item.option_byte - HDR_LEN;
                    ts_next   = ts && (item.option_byte == TS_LEN);
                    if (item.option_byte == HDR_LEN) begin
                        step_mode = MODE_KIND;
                    end else begin
                        step_mode = MODE_BODY;
                        bad       = item.last_in_packet;
                    end
                end
            end
            MODE_BODY: begin
                if (left == '0) begin
                    step_mode = MODE_KIND;
                end else if (item.last_in_packet && left > 8'd1) begin
                    bad = 1'b1;
                end else begin
                    if (ts && left <= TS_BODY) begin
                        ob = ts_byte;
                        rw = 1'b1;
                    end
                    left_next = left - 8'd1;
                    step_mode = (left == 8'd1) ? MODE_KIND : MODE_BODY;
                end
            end
            MODE_DONE: begin
                step_mode = MODE_DONE;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        if (bad) begin
            step_mode = MODE_BAD;
        end
        mode_next = item.last_in_packet ? MODE_KIND : step_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_KIND;
            left_reg <= '0;
            ts_reg   <= 1'b0;
            send_reg <= '0;
            echo_reg <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            left_reg <= left_next;
            ts_reg   <= ts_next;
            send_reg <= send_next;
            echo_reg <= echo_next;
        end
    end

    assign result.out_byte  = ob;
    assign result.out_last  = item.last_in_packet;
    assign result.rewritten = rw;
    assign result.malformed = bad;

endmodule

// ===== design/tsopt_out_stage.sv =====
`timescale 1ns / 1ps

module tsopt_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 d_valid,
    output logic                 d_ready,
    input  tsopt_pkg::out_item_t d_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tsopt_pkg::out_item_t m_item
);
    import tsopt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign d_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (d_ready) begin
            valid_next = d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && d_valid) begin
            item_reg <= d_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

// ===== design/tcp_timestamp_option_rewrite.sv =====
`timescale 1ns / 1ps

// Rewrites the TCP timestamp option in a stream of option-area bytes, one byte per word.
// Mark the first option byte of a segment in s_tuser and the last one with s_tlast; the
// first word also carries now, offset and recent values, which are sampled there. Inside
// a timestamp option (kind 8, length 10) TSval becomes offset plus now and TSecr becomes
// recent, both big-endian; every other byte passes unchanged, and EOL ends parsing. A
// length below two or an option cut off by the last byte raises the malformed flag until
// the segment ends. One word in and one word out every cycle unless m_tready is low;
// words pass an input register, the parse state update and an output register.

module tcp_timestamp_option_rewrite (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // option_byte, now_us, tsval_offset, tsecr_echo
    input  logic [tsopt_pkg::IN_DATA_W-1:0]      s_tdata,
    // first_in_packet
    input  logic [tsopt_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_byte
    output logic [tsopt_pkg::OUT_DATA_W-1:0]     m_tdata,
    // rewritten, malformed
    output logic [tsopt_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                 m_tlast
);
    import tsopt_pkg::*;

    in_item_t  s_item;
    in_item_t  q_item;
    logic      q_valid;
    logic      q_ready;
    out_item_t p_item;
    out_item_t m_item;

    assign s_item.option_byte     = s_tdata[7:0];
    assign s_item.now_us          = s_tdata[39:8];
    assign s_item.tsval_offset    = s_tdata[71:40];
    assign s_item.tsecr_echo      = s_tdata[103:72];
    assign s_item.first_in_packet = s_tuser[0];
    assign s_item.last_in_packet  = s_tlast;

    tsopt_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    tsopt_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (q_valid && q_ready),
        .item    (q_item),
        .result  (p_item)
    );

    tsopt_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .d_valid (q_valid),
        .d_ready (q_ready),
        .d_item  (p_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (m_item)
    );

    assign m_tdata = m_item.out_byte;
    assign m_tlast = m_item.out_last;
    assign m_tuser = {m_item.malformed, m_item.rewritten};

endmodule
